/* rtl/biquad_iir_filter_assert.svh */
// assertion macros for the biquad filter, empty when synthesizing
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, switched off while reset is high
`define BIQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("biquad_iir_filter: assertion failed");

// clocked check that also holds during reset
`define BIQ_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("biquad_iir_filter: assertion failed");

`else

`define BIQ_ASSERT(lbl, clk, rst, prop)
`define BIQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/biq_pkg.sv */
// shared widths, codes and control types of the biquad filter
package biq_pkg;

   localparam int SAMPLE_WIDTH    = 24;
   localparam int COEF_WIDTH      = 32;
   localparam int COEF_FRAC       = COEF_WIDTH - 3;
   localparam int STATE_WIDTH     = 40;
   localparam int PROD_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int RND_WIDTH       = PROD_WIDTH - COEF_FRAC;
   localparam int ACC_WIDTH       = STATE_WIDTH + 2;
   localparam int DATA_WIDTH      = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      COEF_WIDTH'(1) << COEF_FRAC;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [STATE_WIDTH-1:0]  STATE_MAX  = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0]  STATE_MIN  = {1'b1, {(STATE_WIDTH-1){1'b0}}};

   // coefficient select, equal to the register index
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      COEF_B0,
      COEF_B1,
      COEF_B2,
      COEF_A1,
      COEF_A2
   } coef_sel_type;

   typedef enum logic [1:0] {
      BASE_ZERO,
      BASE_Z1,
      BASE_Z2,
      BASE_ACC
   } base_sel_type;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_Y,
      DST_ACC,
      DST_Z1,
      DST_Z2
   } dst_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_OUT_Y,
      ST_FEED_1,
      ST_BACK_1,
      ST_FEED_2,
      ST_BACK_2,
      ST_HOLD
   } state_type;

   typedef struct packed {
      coef_sel_type coef_sel;
      logic         opnd_y;
      base_sel_type base_sel;
      logic         sub;
      dst_type      dst;
      logic         load_x;
      logic         push;
      logic         ready;
   } ctl_type;

endpackage

/* rtl/biq_mac.sv */
// shared multiply, round and accumulate unit
module biq_mac (
   input  logic                                  clock,
   input  logic signed [biq_pkg::COEF_WIDTH-1:0]   coef,
   input  logic signed [biq_pkg::SAMPLE_WIDTH-1:0] opnd,
   input  logic signed [biq_pkg::ACC_WIDTH-1:0]    base,
   input  logic                                  sub,
   output logic signed [biq_pkg::ACC_WIDTH-1:0]    sum
);

   logic signed [biq_pkg::PROD_WIDTH-1:0] prod_in;
   logic signed [biq_pkg::PROD_WIDTH-1:0] prod_ff;
   logic        [biq_pkg::PROD_WIDTH-1:0] mag;
   logic        [biq_pkg::PROD_WIDTH-1:0] mag_rnd;
   logic        [biq_pkg::PROD_WIDTH-1:0] mag_shift;
   logic signed [biq_pkg::RND_WIDTH-1:0]  rnd;
   logic signed [biq_pkg::ACC_WIDTH-1:0]  rnd_ext;

   assign prod_in = coef * opnd;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round to nearest on the magnitude, ties away from zero
   always_comb begin
      mag       = prod_ff[biq_pkg::PROD_WIDTH-1] ? unsigned'(-prod_ff) : unsigned'(prod_ff);
      mag_rnd   = mag + (biq_pkg::PROD_WIDTH'(1) << (biq_pkg::COEF_FRAC - 1));
      mag_shift = mag_rnd >> biq_pkg::COEF_FRAC;
      rnd       = prod_ff[biq_pkg::PROD_WIDTH-1]
                  ? -signed'(mag_shift[biq_pkg::RND_WIDTH-1:0])
                  :  signed'(mag_shift[biq_pkg::RND_WIDTH-1:0]);
      rnd_ext   = biq_pkg::ACC_WIDTH'(rnd);
      sum       = sub ? (base - rnd_ext) : (base + rnd_ext);
   end

endmodule

/* rtl/biq_seq.sv */
// step sequencer that schedules the five products of one sample
module biq_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             out_free,
   output biq_pkg::ctl_type ctl
);

   biq_pkg::state_type state_ff;
   biq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= biq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl.coef_sel = biq_pkg::COEF_B0;
      ctl.opnd_y   = 1'b0;
      ctl.base_sel = biq_pkg::BASE_ZERO;
      ctl.sub      = 1'b0;
      ctl.dst      = biq_pkg::DST_NONE;
      ctl.load_x   = 1'b0;
      ctl.push     = 1'b0;
      ctl.ready    = 1'b0;
      case (state_ff)
         biq_pkg::ST_IDLE: begin
            ctl.ready  = 1'b1;
            ctl.load_x = req_tvalid;
            if (req_tvalid) begin
               state_in = biq_pkg::ST_MUL_B0;
            end
         end
         biq_pkg::ST_MUL_B0: begin
            ctl.coef_sel = biq_pkg::COEF_B0;
            state_in     = biq_pkg::ST_OUT_Y;
         end
         biq_pkg::ST_OUT_Y: begin
            ctl.coef_sel = biq_pkg::COEF_B1;
            ctl.base_sel = biq_pkg::BASE_Z1;
            ctl.dst      = biq_pkg::DST_Y;
            state_in     = biq_pkg::ST_FEED_1;
         end
         biq_pkg::ST_FEED_1: begin
            ctl.coef_sel = biq_pkg::COEF_A1;
            ctl.opnd_y   = 1'b1;
            ctl.base_sel = biq_pkg::BASE_Z2;
            ctl.dst      = biq_pkg::DST_ACC;
            state_in     = biq_pkg::ST_BACK_1;
         end
         biq_pkg::ST_BACK_1: begin
            ctl.coef_sel = biq_pkg::COEF_B2;
            ctl.base_sel = biq_pkg::BASE_ACC;
            ctl.sub      = 1'b1;
            ctl.dst      = biq_pkg::DST_Z1;
            state_in     = biq_pkg::ST_FEED_2;
         end
         biq_pkg::ST_FEED_2: begin
            ctl.coef_sel = biq_pkg::COEF_A2;
            ctl.opnd_y   = 1'b1;
            ctl.base_sel = biq_pkg::BASE_ZERO;
            ctl.dst      = biq_pkg::DST_ACC;
            state_in     = biq_pkg::ST_BACK_2;
         end
         biq_pkg::ST_BACK_2: begin
            ctl.base_sel = biq_pkg::BASE_ACC;
            ctl.sub      = 1'b1;
            ctl.dst      = biq_pkg::DST_Z2;
            ctl.push     = out_free;
            state_in     = out_free ? biq_pkg::ST_IDLE : biq_pkg::ST_HOLD;
         end
         biq_pkg::ST_HOLD: begin
            ctl.push = out_free;
            if (out_free) begin
               state_in = biq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = biq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/biquad_iir_filter.sv */
// biquad filter top: one sample accepted, then six steps through one shared multiplier
// rsp_tvalid rises from the output register after BACK_2 (or HOLD, while the output is full) pushes the result
// a new sample is taken only after the last one is pushed; the single multiplier handles the five
//   products in turn and the sample after it waits for the delay update
// reset (synchronous, active high): delay line cleared, b0 = 1.0 and the
//   other coefficients 0 so samples pass through, output register empty
module biquad_iir_filter (
   input  logic                             clock,
   input  logic                             reset,
   // input sample beat
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [biq_pkg::DATA_WIDTH-1:0]   req_tdata,   // [23:0] sample_in
   // filtered sample beat
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [biq_pkg::DATA_WIDTH-1:0]   rsp_tdata,   // [23:0] sample_out
   output logic [0:0]                       rsp_tuser,   // [0] clipped
   // coefficient writes
   input  logic                                  csr_wen,
   input  logic [biq_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [biq_pkg::COEF_WIDTH-1:0]        csr_wdata
);

`include "biquad_iir_filter_assert.svh"

   // coefficient registers, Q3.29
   logic signed [biq_pkg::COEF_WIDTH-1:0] coef_feed_0_ff;
   logic signed [biq_pkg::COEF_WIDTH-1:0] coef_feed_1_ff;
   logic signed [biq_pkg::COEF_WIDTH-1:0] coef_feed_2_ff;
   logic signed [biq_pkg::COEF_WIDTH-1:0] coef_back_1_ff;
   logic signed [biq_pkg::COEF_WIDTH-1:0] coef_back_2_ff;

   // sample, output and delay line
   logic signed [biq_pkg::SAMPLE_WIDTH-1:0] x_ff;
   logic signed [biq_pkg::SAMPLE_WIDTH-1:0] y_ff;
   logic signed [biq_pkg::SAMPLE_WIDTH-1:0] y_in;
   logic                                    clip_ff;
   logic                                    clip_in;
   logic signed [biq_pkg::ACC_WIDTH-1:0]    acc_ff;
   logic signed [biq_pkg::STATE_WIDTH-1:0]  delay_one_ff;
   logic signed [biq_pkg::STATE_WIDTH-1:0]  delay_two_ff;
   logic signed [biq_pkg::STATE_WIDTH-1:0]  state_sat;

   // output register
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic signed [biq_pkg::SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                                    rsp_clip_ff;
   logic                                    rsp_at_limit;

   // shared unit operands
   logic signed [biq_pkg::COEF_WIDTH-1:0]   mac_coef;
   logic signed [biq_pkg::SAMPLE_WIDTH-1:0] mac_opnd;
   logic signed [biq_pkg::ACC_WIDTH-1:0]    mac_base;
   logic signed [biq_pkg::ACC_WIDTH-1:0]    mac_sum;

   logic             out_free;
   biq_pkg::ctl_type ctl;

   // output register can take a result this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   biq_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   assign req_tready = ctl.ready;

   // coefficient writes; indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_feed_0_ff <= biq_pkg::COEF_ONE;
         coef_feed_1_ff <= '0;
         coef_feed_2_ff <= '0;
         coef_back_1_ff <= '0;
         coef_back_2_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            biq_pkg::COEF_B0: coef_feed_0_ff <= signed'(csr_wdata);
            biq_pkg::COEF_B1: coef_feed_1_ff <= signed'(csr_wdata);
            biq_pkg::COEF_B2: coef_feed_2_ff <= signed'(csr_wdata);
            biq_pkg::COEF_A1: coef_back_1_ff <= signed'(csr_wdata);
            biq_pkg::COEF_A2: coef_back_2_ff <= signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (ctl.coef_sel)
         biq_pkg::COEF_B0: mac_coef = coef_feed_0_ff;
         biq_pkg::COEF_B1: mac_coef = coef_feed_1_ff;
         biq_pkg::COEF_B2: mac_coef = coef_feed_2_ff;
         biq_pkg::COEF_A1: mac_coef = coef_back_1_ff;
         biq_pkg::COEF_A2: mac_coef = coef_back_2_ff;
         default:          mac_coef = coef_feed_0_ff;
      endcase
      mac_opnd = ctl.opnd_y ? y_ff : x_ff;
      case (ctl.base_sel)
         biq_pkg::BASE_ZERO: mac_base = '0;
         biq_pkg::BASE_Z1:   mac_base = biq_pkg::ACC_WIDTH'(delay_one_ff);
         biq_pkg::BASE_Z2:   mac_base = biq_pkg::ACC_WIDTH'(delay_two_ff);
         biq_pkg::BASE_ACC:  mac_base = acc_ff;
         default:            mac_base = '0;
      endcase
   end

   // product of the previous step is rounded and added here
   biq_mac u_mac (
      .clock (clock),
      .coef  (mac_coef),
      .opnd  (mac_opnd),
      .base  (mac_base),
      .sub   (ctl.sub),
      .sum   (mac_sum)
   );

   // saturation of the unit's sum: to the sample range for y, to 40 bits for the delays
   always_comb begin
      if ((&mac_sum[biq_pkg::ACC_WIDTH-1:biq_pkg::SAMPLE_WIDTH-1]) ||
          !(|mac_sum[biq_pkg::ACC_WIDTH-1:biq_pkg::SAMPLE_WIDTH-1])) begin
         y_in    = mac_sum[biq_pkg::SAMPLE_WIDTH-1:0];
         clip_in = 1'b0;
      end else begin
         y_in    = mac_sum[biq_pkg::ACC_WIDTH-1] ? biq_pkg::SAMPLE_MIN : biq_pkg::SAMPLE_MAX;
         clip_in = 1'b1;
      end
      if ((&mac_sum[biq_pkg::ACC_WIDTH-1:biq_pkg::STATE_WIDTH-1]) ||
          !(|mac_sum[biq_pkg::ACC_WIDTH-1:biq_pkg::STATE_WIDTH-1])) begin
         state_sat = mac_sum[biq_pkg::STATE_WIDTH-1:0];
      end else begin
         state_sat = mac_sum[biq_pkg::ACC_WIDTH-1] ? biq_pkg::STATE_MIN : biq_pkg::STATE_MAX;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctl.load_x) begin
         x_ff <= signed'(req_tdata[biq_pkg::SAMPLE_WIDTH-1:0]);
      end
      if (ctl.dst == biq_pkg::DST_Y) begin
         y_ff    <= y_in;
         clip_ff <= clip_in;
      end
      if (ctl.dst == biq_pkg::DST_ACC) begin
         acc_ff <= mac_sum;
      end
      if (ctl.push) begin
         rsp_sample_ff <= y_ff;
         rsp_clip_ff   <= clip_ff;
      end
   end

   // delay line is filter state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_one_ff <= '0;
         delay_two_ff <= '0;
      end else begin
         if (ctl.dst == biq_pkg::DST_Z1) begin
            delay_one_ff <= state_sat;
         end
         if (ctl.dst == biq_pkg::DST_Z2) begin
            delay_two_ff <= state_sat;
         end
      end
   end

   // output beat holds until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = biq_pkg::DATA_WIDTH'(unsigned'(rsp_sample_ff));
   assign rsp_tuser  = rsp_clip_ff;

   // waiting sample sits on one of the range limits
   assign rsp_at_limit = (rsp_sample_ff == biq_pkg::SAMPLE_MAX) ||
                         (rsp_sample_ff == biq_pkg::SAMPLE_MIN);

   // a sample runs for several steps, so no second beat right after one
   `BIQ_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // a result is never pushed over one that is still waiting
   `BIQ_ASSERT(a_no_overrun, clock, reset, (ctl.push && rsp_valid_ff) |-> rsp_tready)

   // a clipped result sits at one of the range limits
   `BIQ_ASSERT(a_clip_at_limit, clock, reset, (rsp_valid_ff && rsp_clip_ff) |-> rsp_at_limit)

   // no output beat in the cycle after a reset edge
   `BIQ_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule
